@@ sv/pending_pair_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pending pair table core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PENDING_PAIR_TABLE_CORE_DEFINES_SVH
`define PENDING_PAIR_TABLE_CORE_DEFINES_SVH

// condition holds at every edge
`define PPT_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// trigger at one edge implies consequence at the next
`define PPT_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// Types and constants shared by the pending pair table core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ID_W    = 32;
    localparam int STAMP_W = 32;
    localparam int FILL_W  = 7;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

    typedef enum logic {
        FUNC_RECORD = 1'b0,
        FUNC_CLAIM  = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CMP,
        OP_REFRESH,
        OP_APPEND,
        OP_REMOVE,
        OP_REPLACE
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_SEED,
        ST_SCAN,
        ST_REPLACE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    dst;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        t_cell_op          op;
        t_entry            req;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  tgt;
    } t_cell_ctrl;

    // running minimum walking along the row
    typedef struct packed {
        logic               vld;
        logic [STAMP_W-1:0] stamp;
        logic [IDX_W-1:0]   idx;
    } t_token;

endpackage

@@ sv/ppt_in_if.sv @@
// ----------------------------------------------------------------------------
// ppt_in_if
// Request channel: one word is a func / source / destination / stamp request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppt_in_if;
    import ppt_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [ID_W-1:0]    src_id;
    logic [ID_W-1:0]    dst_id;
    logic [STAMP_W-1:0] stamp;

    modport source (output valid, func, src_id, dst_id, stamp, input ready);
    modport sink   (input valid, func, src_id, dst_id, stamp, output ready);
endinterface

@@ sv/ppt_out_if.sv @@
// ----------------------------------------------------------------------------
// ppt_out_if
// Response channel: one word is hit / evicted / fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppt_out_if;
    import ppt_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic              evicted;
    logic [FILL_W-1:0] fill;

    modport source (output valid, hit, evicted, fill, input ready);
    modport sink   (input valid, hit, evicted, fill, output ready);
endinterface

@@ sv/ppt_cell.sv @@
// ----------------------------------------------------------------------------
// ppt_cell
// One table slot: holds an entry, compares it, shifts from its upper
// neighbour and passes the minimum-stamp token downstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ppt_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ppt_pkg::IDX_W-1:0] i_idx,
    input  ppt_pkg::t_entry           i_next,
    output ppt_pkg::t_entry           o_ent,
    input  logic                      i_seen,
    output logic                      o_seen,
    input  ppt_pkg::t_token           i_tok,
    output ppt_pkg::t_token           o_tok
);
    import ppt_pkg::*;

    t_entry             r_ent;
    logic               r_match;
    logic               r_tok_vld;
    logic [STAMP_W-1:0] r_tok_stamp;
    logic [IDX_W-1:0]   r_tok_idx;

    logic w_live;
    logic w_first;
    logic w_at_count;

    assign w_live     = CNT_W'(i_idx) < i_ctrl.count;
    assign w_at_count = CNT_W'(i_idx) == i_ctrl.count;
    assign w_first    = r_match & ~i_seen;
    assign o_seen     = i_seen | r_match;
    assign o_ent      = r_ent;
    assign o_tok      = '{vld: r_tok_vld, stamp: r_tok_stamp, idx: r_tok_idx};

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_REFRESH: begin
                if (w_first) r_ent.stamp <= i_ctrl.req.stamp;
            end
            OP_APPEND: begin
                if (w_at_count) r_ent <= i_ctrl.req;
            end
            OP_REMOVE: begin
                // first match and everything above it move down one place
                if (o_seen) r_ent <= i_next;
            end
            OP_REPLACE: begin
                if (i_idx == i_ctrl.tgt) r_ent <= i_ctrl.req;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_CMP) begin
            r_match <= w_live && (r_ent.src == i_ctrl.req.src)
                              && (r_ent.dst == i_ctrl.req.dst);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok.vld;
        end
    end

    // strict less keeps the lower index on a tie
    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            if (r_ent.stamp < i_tok.stamp) begin
                r_tok_stamp <= r_ent.stamp;
                r_tok_idx   <= i_idx;
            end else begin
                r_tok_stamp <= i_tok.stamp;
                r_tok_idx   <= i_tok.idx;
            end
        end
    end

endmodule

@@ sv/pending_pair_table_core.sv @@
// ----------------------------------------------------------------------------
// Path: a record into a non-full table or a claim passes ST_CMP and ST_APPLY;
//   a record into a full table passes ST_SEED, ST_SCAN (the minimum-stamp token
//   walks the row) and ST_REPLACE. ST_APPLY and ST_REPLACE wait for a free response register.
// Throughput: one request at a time; the next is accepted only back in ST_IDLE.
// Reset: synchronous, active low; clears the fill count, FSM and handshake.
//   Slot contents are not cleared; only slots below the fill count are read.
// ----------------------------------------------------------------------------
// pending_pair_table_core
// Bounded table of (source, destination, stamp) entries packed from slot 0,
// built as a row of ppt_cell slots driven by one broadcast control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pending_pair_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppt_in_if.sink      i_req,
    ppt_out_if.source   o_rsp
);
    import ppt_pkg::*;

    // FSM and request hold
    t_state             r_state, n_state;
    logic               r_func;
    t_entry             r_req;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_tgt;

    // response word register; parts the two handshakes
    logic               r_out_vld;
    logic               r_out_hit;
    logic               r_out_evict;
    logic [FILL_W-1:0]  r_out_fill;

    logic               w_in_fire;
    logic               w_out_free;
    logic               w_fire;
    logic               w_hit;
    logic               w_evict;
    logic               w_seed;
    logic               w_any;
    logic               w_full;
    t_cell_op           w_op;
    t_cell_ctrl         w_ctrl;

    // cell row links
    t_entry             w_ent  [ENTRIES];
    logic               w_seen [ENTRIES+1];
    t_token             w_tok  [ENTRIES+1];

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_in_fire   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_vld || o_rsp.ready;
    assign w_full      = (r_count == CNT_W'(ENTRIES));
    assign w_any       = w_seen[ENTRIES];

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.hit     = r_out_hit;
    assign o_rsp.evicted = r_out_evict;
    assign o_rsp.fill    = r_out_fill;

    assign w_ctrl = '{op: w_op, req: r_req, count: r_count, tgt: r_tgt};

    // seen chain starts clear; token seeded with the all-ones stamp at slot 0
    assign w_seen[0] = 1'b0;
    assign w_tok[0]  = '{vld: w_seed, stamp: STAMP_MAX, idx: '0};

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_next;
        // top slot has no upper neighbour; it falls outside the fill after a removal
        if (g == ENTRIES - 1) begin : g_top
            assign w_next = w_ent[g];
        end else begin : g_mid
            assign w_next = w_ent[g+1];
        end

        ppt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_idx   (IDX_W'(g)),
            .i_next  (w_next),
            .o_ent   (w_ent[g]),
            .i_seen  (w_seen[g]),
            .o_seen  (w_seen[g+1]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        w_op    = OP_NONE;
        w_fire  = 1'b0;
        w_hit   = 1'b0;
        w_evict = 1'b0;
        w_seed  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    // a full table record skips the duplicate search
                    if ((t_func'(i_req.func) == FUNC_RECORD) && w_full) begin
                        n_state = ST_SEED;
                    end else begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                w_op    = OP_CMP;
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (w_out_free) begin
                    w_fire  = 1'b1;
                    w_hit   = w_any;
                    n_state = ST_IDLE;
                    if (t_func'(r_func) == FUNC_RECORD) begin
                        if (w_any) begin
                            w_op = OP_REFRESH;
                        end else begin
                            w_op    = OP_APPEND;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (w_any) begin
                        w_op    = OP_REMOVE;
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            ST_SEED: begin
                w_seed  = 1'b1;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_tok[ENTRIES].vld) n_state = ST_REPLACE;
            end
            ST_REPLACE: begin
                if (w_out_free) begin
                    w_fire  = 1'b1;
                    w_evict = 1'b1;
                    w_op    = OP_REPLACE;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // request hold
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_func    <= i_req.func;
            r_req.src <= i_req.src_id;
            r_req.dst <= i_req.dst_id;
            r_req.stamp <= i_req.stamp;
        end
    end

    // eviction slot from the end of the row
    always_ff @(posedge i_clk) begin
        if (w_tok[ENTRIES].vld) r_tgt <= w_tok[ENTRIES].idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_hit   <= w_hit;
            r_out_evict <= w_evict;
            r_out_fill  <= FILL_W'(n_count);
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
`include "pending_pair_table_core_defines.svh"

    `PPT_ASSERT(a_count_bound, r_count <= CNT_W'(ENTRIES), "fill count beyond table size")
    `PPT_ASSERT(a_hit_xor_evict, !(r_out_vld && r_out_hit && r_out_evict), "hit with eviction")
    `PPT_ASSERT(a_token_in_scan, !w_tok[ENTRIES].vld || (r_state == ST_SCAN), "stray scan token")
    `PPT_ASSERT_NEXT(a_accept_route, w_in_fire, (r_state == ST_CMP) || (r_state == ST_SEED), "accept route")
    `PPT_ASSERT_NEXT(a_evict_full, w_fire && w_evict, r_count == CNT_W'(ENTRIES), "evict not full")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for pending_pair_table_core
// The test starts with a short table of directed requests: the extreme field
// values, refresh, append, claim hit and claim miss. Random traffic follows in
// phases. The first is a mixed phase, and in it the response side holds off
// for a long stretch. Then comes a burst with no idling that fills the table
// and goes on into full-table eviction, duplicates and claims. Then the table
// is saturated with equal stamps, then drained, and a last mixed phase ends
// the run. Response words are checked against typed rows or a local model.
// ----------------------------------------------------------------------------

module testbench;
    import ppt_pkg::*;

    localparam int  IDLE_PCT     = 31;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  POOL_SIZE    = 16;
    localparam int  TARGET_ITEMS = 625;
    localparam int  DRAIN_CYCLES = ENTRIES + 8;
    localparam real TIMEOUT_NS   = 10_000_000.0;

    // one response word as the block should produce it
    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [FILL_W-1:0] fill;
    } t_rsp_word;

    // a directed request; typed rows carry their expected response word
    typedef struct {
        t_func              func;
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    dst;
        logic [STAMP_W-1:0] stamp;
        bit                 typed;
        t_rsp_word          rsp;
    } t_stim_row;

    localparam logic [ID_W-1:0] ID_MAX = 32'hFFFF_FFFF;
    localparam t_rsp_word       NO_RSP = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppt_in_if  req_if ();
    ppt_out_if rsp_if ();

    pending_pair_table_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 0;
    end

    // ------------------------------------------------------------------------
    // Local model of the table: packed from slot 0, fill entries valid
    // ------------------------------------------------------------------------
    logic [ID_W-1:0]    tbl_src   [ENTRIES];
    logic [ID_W-1:0]    tbl_dst   [ENTRIES];
    logic [STAMP_W-1:0] tbl_stamp [ENTRIES];
    int                 tbl_fill = 0;

    t_rsp_word pending_rsps [$];

    // pool of pairs reused often so that refreshes and claim hits are common
    logic [ID_W-1:0] pool_src [POOL_SIZE];
    logic [ID_W-1:0] pool_dst [POOL_SIZE];

    bit idle_on   = 1'b1;
    int hold_req  = 0;
    int err_count = 0;

    int n_items  = 0;
    int n_record = 0;
    int n_claim  = 0;
    int n_hit    = 0;
    int n_evict  = 0;
    int n_rsp    = 0;
    int max_fill = 0;

    // Apply one request to the model and return the response word it gives.
    // A record into a full table skips the duplicate search and replaces the
    // oldest stamp, lowest slot winning a tie.
    function automatic t_rsp_word table_apply(t_func f, logic [ID_W-1:0] s,
                                              logic [ID_W-1:0] d,
                                              logic [STAMP_W-1:0] t);
        t_rsp_word r;
        int        pos;
        int        best;
        r   = '0;
        pos = -1;
        for (int i = 0; i < tbl_fill; i++) begin
            if (pos < 0 && tbl_src[i] == s && tbl_dst[i] == d) pos = i;
        end
        if (f == FUNC_RECORD) begin
            if (tbl_fill < ENTRIES) begin
                if (pos >= 0) begin
                    tbl_stamp[pos] = t;
                    r.hit = 1'b1;
                end else begin
                    tbl_src[tbl_fill]   = s;
                    tbl_dst[tbl_fill]   = d;
                    tbl_stamp[tbl_fill] = t;
                    tbl_fill++;
                end
            end else begin
                best = 0;
                for (int i = 1; i < ENTRIES; i++) begin
                    if (tbl_stamp[i] < tbl_stamp[best]) best = i;
                end
                tbl_src[best]   = s;
                tbl_dst[best]   = d;
                tbl_stamp[best] = t;
                r.evicted = 1'b1;
            end
        end else if (pos >= 0) begin
            // close the gap: later entries move down one slot
            for (int i = pos; i < tbl_fill - 1; i++) begin
                tbl_src[i]   = tbl_src[i + 1];
                tbl_dst[i]   = tbl_dst[i + 1];
                tbl_stamp[i] = tbl_stamp[i + 1];
            end
            tbl_fill--;
            r.hit = 1'b1;
        end
        r.fill = tbl_fill[FILL_W-1:0];
        return r;
    endfunction

    // stamps lean on the extremes and a narrow range so that ties occur
    function automatic logic [STAMP_W-1:0] pick_stamp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)      return '0;
        else if (sel < 20) return STAMP_MAX;
        else if (sel < 40) return STAMP_W'($urandom_range(7));
        else               return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Valid is only lowered when a gap is taken, so a word that
    // follows straight on keeps valid high.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_func f, input logic [ID_W-1:0] s,
                             input logic [ID_W-1:0] d, input logic [STAMP_W-1:0] t,
                             input bit typed, input t_rsp_word typed_rsp);
        t_rsp_word predicted;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.func   <= f;
        req_if.src_id <= s;
        req_if.dst_id <= d;
        req_if.stamp  <= t;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        // word taken at this edge
        predicted = table_apply(f, s, d, t);
        pending_rsps.push_back(typed ? typed_rsp : predicted);
        n_items++;
        if (f == FUNC_RECORD) n_record++;
        else                  n_claim++;
        if (predicted.hit)     n_hit++;
        if (predicted.evicted) n_evict++;
        if (tbl_fill > max_fill) max_fill = tbl_fill;
    endtask

    // mixed records and claims, mostly on pooled pairs
    task automatic send_random_mix(input int count);
        t_func           f;
        logic [ID_W-1:0] s;
        logic [ID_W-1:0] d;
        int              sel;
        int              k;
        repeat (count) begin
            f   = ($urandom_range(99) < 55) ? FUNC_RECORD : FUNC_CLAIM;
            sel = $urandom_range(99);
            if (sel < 70) begin
                k = $urandom_range(POOL_SIZE - 1);
                s = pool_src[k];
                d = pool_dst[k];
            end else if (sel < 85 && tbl_fill > 0) begin
                k = $urandom_range(tbl_fill - 1);
                s = tbl_src[k];
                d = tbl_dst[k];
            end else begin
                s = $urandom;
                d = $urandom;
            end
            send_word(f, s, d, pick_stamp(), 1'b0, NO_RSP);
        end
    endtask

    // records of fresh random pairs until the table is full
    task automatic fill_table(input logic [STAMP_W-1:0] fixed_stamp, input bit use_fixed);
        while (tbl_fill < ENTRIES) begin
            send_word(FUNC_RECORD, $urandom, $urandom,
                      use_fixed ? fixed_stamp : pick_stamp(), 1'b0, NO_RSP);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: check each word taken, then pick ready for the next
    // cycle. A hold-off request from the main flow drops ready for a long
    // stretch, counted here, while requests keep coming.
    // ------------------------------------------------------------------------
    int        hold_seen = 0;
    int        hold_left = 0;
    t_rsp_word got_rsp;
    t_rsp_word exp_rsp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_rsp = '{rsp_if.hit, rsp_if.evicted, rsp_if.fill};
                n_rsp++;
                if (pending_rsps.size() == 0) begin
                    $display("%0t: response word with none expected: hit=%0b evicted=%0b fill=%0d",
                             $time, got_rsp.hit, got_rsp.evicted, got_rsp.fill);
                    err_count++;
                end else begin
                    exp_rsp = pending_rsps.pop_front();
                    if (got_rsp.hit !== exp_rsp.hit) begin
                        $display("%0t: hit mismatch: expected %0b, got %0b",
                                 $time, exp_rsp.hit, got_rsp.hit);
                        err_count++;
                    end
                    if (got_rsp.evicted !== exp_rsp.evicted) begin
                        $display("%0t: evicted mismatch: expected %0b, got %0b",
                                 $time, exp_rsp.evicted, got_rsp.evicted);
                        err_count++;
                    end
                    if (got_rsp.fill !== exp_rsp.fill) begin
                        $display("%0t: fill mismatch: expected %0d, got %0d",
                                 $time, exp_rsp.fill, got_rsp.fill);
                        err_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen    <= hold_req;
                hold_left    <= HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed requests. Typed rows: right after reset, the extremes, refresh
    // and the claim cases whose answer is plain; the rest use the model.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [17] = '{
        // claim on an empty table
        '{FUNC_CLAIM,  32'h0,        32'h0,        32'h0,        1'b1, '{1'b0, 1'b0, 7'd0}},
        '{FUNC_RECORD, 32'h0,        32'h0,        32'h0,        1'b1, '{1'b0, 1'b0, 7'd1}},
        '{FUNC_RECORD, ID_MAX,       ID_MAX,       STAMP_MAX,    1'b1, '{1'b0, 1'b0, 7'd2}},
        // same pair again: refresh, fill unchanged
        '{FUNC_RECORD, 32'h0,        32'h0,        STAMP_MAX,    1'b1, '{1'b1, 1'b0, 7'd2}},
        // pairs sharing one half with an existing pair are distinct
        '{FUNC_RECORD, ID_MAX,       32'h0,        32'h0,        1'b1, '{1'b0, 1'b0, 7'd3}},
        '{FUNC_RECORD, 32'h0,        ID_MAX,       32'h1,        1'b1, '{1'b0, 1'b0, 7'd4}},
        '{FUNC_CLAIM,  ID_MAX,       32'h0,        32'h0,        1'b1, '{1'b1, 1'b0, 7'd3}},
        // claim of a pair just removed misses
        '{FUNC_CLAIM,  ID_MAX,       32'h0,        32'h0,        1'b1, '{1'b0, 1'b0, 7'd3}},
        '{FUNC_RECORD, 32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_5555, 1'b0, NO_RSP},
        '{FUNC_RECORD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NO_RSP},
        // claim of slot 0 shifts every later entry
        '{FUNC_CLAIM,  32'h0,        32'h0,        32'h0,        1'b0, NO_RSP},
        '{FUNC_CLAIM,  32'h0,        ID_MAX,       32'h0,        1'b0, NO_RSP},
        '{FUNC_RECORD, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0,        1'b0, NO_RSP},
        // stamp on a claim has no effect
        '{FUNC_CLAIM,  32'hAAAA_AAAA, 32'h5555_5555, STAMP_MAX,    1'b0, NO_RSP},
        '{FUNC_CLAIM,  ID_MAX,       ID_MAX,       32'h0,        1'b0, NO_RSP},
        '{FUNC_CLAIM,  32'h1234_5678, 32'h9ABC_DEF0, 32'h0,        1'b1, '{1'b1, 1'b0, 7'd0}},
        '{FUNC_CLAIM,  32'h0,        32'h0,        32'h0,        1'b1, '{1'b0, 1'b0, 7'd0}}
    };

    initial begin
        int k;
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.func   <= FUNC_RECORD;
        req_if.src_id <= '0;
        req_if.dst_id <= '0;
        req_if.stamp  <= '0;

        pool_src[0] = '0;
        pool_dst[0] = '0;
        pool_src[1] = ID_MAX;
        pool_dst[1] = ID_MAX;
        for (int i = 2; i < POOL_SIZE; i++) begin
            pool_src[i] = $urandom;
            pool_dst[i] = $urandom;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].func, directed_rows[i].src, directed_rows[i].dst,
                      directed_rows[i].stamp, directed_rows[i].typed, directed_rows[i].rsp);
        end

        // mixed traffic, with a long hold-off on the response side in the middle
        idle_on = 1'b1;
        send_random_mix(120);
        hold_req++;
        send_random_mix(80);

        // no idling from here until the table has been refilled
        idle_on = 1'b0;
        fill_table('0, 1'b0);
        // full table: eviction, including pairs already present (duplicates)
        repeat (60) begin
            if ($urandom_range(1)) begin
                k = $urandom_range(tbl_fill - 1);
                send_word(FUNC_RECORD, tbl_src[k], tbl_dst[k], pick_stamp(), 1'b0, NO_RSP);
            end else begin
                k = $urandom_range(POOL_SIZE - 1);
                send_word(FUNC_RECORD, pool_src[k], pool_dst[k], pick_stamp(), 1'b0, NO_RSP);
            end
        end
        // claims; a pair stored twice loses only its lower copy
        repeat (40) begin
            k = $urandom_range(99);
            if (k < 50 && tbl_fill > 0) begin
                k = $urandom_range(tbl_fill - 1);
                send_word(FUNC_CLAIM, tbl_src[k], tbl_dst[k], pick_stamp(), 1'b0, NO_RSP);
            end else if (k < 80) begin
                k = $urandom_range(POOL_SIZE - 1);
                send_word(FUNC_CLAIM, pool_src[k], pool_dst[k], pick_stamp(), 1'b0, NO_RSP);
            end else begin
                send_word(FUNC_CLAIM, $urandom, $urandom, pick_stamp(), 1'b0, NO_RSP);
            end
        end
        fill_table('0, 1'b0);

        // saturate with maximum stamps until every stamp is equal; the
        // records after that all land on slot 0
        idle_on = 1'b1;
        repeat (ENTRIES + 6) begin
            send_word(FUNC_RECORD, $urandom, $urandom, STAMP_MAX, 1'b0, NO_RSP);
        end
        send_word(FUNC_RECORD, $urandom, $urandom, '0, 1'b0, NO_RSP);
        send_word(FUNC_RECORD, $urandom, $urandom, STAMP_MAX, 1'b0, NO_RSP);

        // drain, with the odd claim that misses
        while (tbl_fill > 0) begin
            if ($urandom_range(99) < 85) begin
                k = $urandom_range(tbl_fill - 1);
                send_word(FUNC_CLAIM, tbl_src[k], tbl_dst[k], pick_stamp(), 1'b0, NO_RSP);
            end else begin
                send_word(FUNC_CLAIM, $urandom, $urandom, pick_stamp(), 1'b0, NO_RSP);
            end
        end

        if (n_items < TARGET_ITEMS) send_random_mix(TARGET_ITEMS - n_items);

        @(posedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsps.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (%0d record, %0d claim), %0d response words checked.",
                 n_items, n_record, n_claim, n_rsp);
        $display("Hits %0d, full-table evictions %0d, peak fill %0d of %0d.",
                 n_hit, n_evict, max_fill, ENTRIES);
        if (err_count == 0 && pending_rsps.size() == 0) begin
            $display("** pending_pair_table_core: PASSED **");
        end else begin
            $display("** pending_pair_table_core: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d response words outstanding", $time, pending_rsps.size());
        $display("** pending_pair_table_core: FAILED **");
        $finish;
    end

endmodule
